// ----- rtl/tdh_pkg.sv -----
// Shared types and constants for the two-dimensional nearest-centre histogram.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none

package tdh_pkg;

	// field widths
	localparam int VALUE_W = 16;
	localparam int COUNT_W = 32;
	localparam int IDX_W   = 4;
	localparam int USED_W  = 5;

	// bins per dimension (one centre cell per bin)
	localparam int BINS_FIRST  = 16;
	localparam int BINS_SECOND = 16;

	// count store, entry (a, b) at b * BINS_FIRST + a
	localparam int STORE_DEPTH = BINS_FIRST * BINS_SECOND;
	localparam int ADDR_W      = 2 * IDX_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// operation codes of the sample word
	typedef enum logic [1:0] {
		OP_LOAD_FIRST  = 2'd0,
		OP_LOAD_SECOND = 2'd1,
		OP_ADD         = 2'd2,
		OP_READ        = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [0:0] REG_BINS_FIRST  = 1'b0;
	localparam logic [0:0] REG_BINS_SECOND = 1'b1;

	// search token handed from cell to cell
	typedef struct packed {
		logic                      valid;
		logic                      done;
		logic signed [VALUE_W:0]   v2;
		logic        [IDX_W-1:0]   bin;
	} tok_t;

endpackage

`default_nettype wire

// ----- rtl/tdh_if.sv -----
// Valid/ready channel interfaces for the sample and result words.
// Depends on tdh_pkg for field widths.
`default_nettype none

interface tdh_sample_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          op;
	logic [tdh_pkg::IDX_W-1:0]           index_first;
	logic [tdh_pkg::IDX_W-1:0]           index_second;
	logic signed [tdh_pkg::VALUE_W-1:0]  value_first;
	logic signed [tdh_pkg::VALUE_W-1:0]  value_second;

	modport source (
		output valid, op, index_first, index_second, value_first, value_second,
		input  ready
	);
	modport sink (
		input  valid, op, index_first, index_second, value_first, value_second,
		output ready
	);
endinterface

interface tdh_result_if;
	logic                          valid;
	logic                          ready;
	logic [tdh_pkg::IDX_W-1:0]     bin_first;
	logic [tdh_pkg::IDX_W-1:0]     bin_second;
	logic [tdh_pkg::COUNT_W-1:0]   count;

	modport source (
		output valid, bin_first, bin_second, count,
		input  ready
	);
	modport sink (
		input  valid, bin_first, bin_second, count,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/tdh_cell.sv -----
// One centre cell: holds centre j and tests the passing search token against
// the midpoint of centres j and j+1. Depends on tdh_pkg.
`default_nettype none

module tdh_cell #(
	parameter int IDX = 0
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 ld_en,
	input  wire signed [tdh_pkg::VALUE_W-1:0]   ld_value,
	input  wire signed [tdh_pkg::VALUE_W-1:0]   c_next,
	input  wire        [tdh_pkg::USED_W-1:0]    used,
	input  tdh_pkg::tok_t                       tok_in,
	output logic signed [tdh_pkg::VALUE_W-1:0]  c_own,
	output tdh_pkg::tok_t                       tok_q
);
	import tdh_pkg::*;

	logic signed [VALUE_W:0] mid_sum;
	logic                    has_next;
	logic                    take;
	tok_t                    tok_d;

	// centre storage, undefined until loaded
	always_ff @(posedge clk) begin
		if (ld_en) begin
			c_own <= ld_value;
		end
	end

	// midpoint test, exact: 2v < c[j] + c[j+1]; beyond the bins in use, stop here
	always_comb begin
		mid_sum  = (VALUE_W+1)'(c_own) + (VALUE_W+1)'(c_next);
		has_next = USED_W'(IDX + 1) < used;
		take     = tok_in.valid && !tok_in.done && (!has_next || (tok_in.v2 < mid_sum));
		tok_d       = tok_in;
		tok_d.done  = tok_in.done | take;
		tok_d.bin   = take ? IDX_W'(IDX) : tok_in.bin;
	end

	// hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tdh_chain.sv -----
// Row of centre cells for one dimension; a token walks one cell per cycle.
// Depends on tdh_pkg and tdh_cell.
`default_nettype none

module tdh_chain #(
	parameter int N = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                ld_en,
	input  wire        [tdh_pkg::IDX_W-1:0]    ld_idx,
	input  wire signed [tdh_pkg::VALUE_W-1:0]  ld_value,
	input  wire        [tdh_pkg::USED_W-1:0]   used,
	input  tdh_pkg::tok_t                      tok_start,
	output tdh_pkg::tok_t                      res
);
	import tdh_pkg::*;

	tok_t                     tok [N+1];
	logic signed [VALUE_W-1:0] ctr [N];

	assign tok[0] = tok_start;
	assign res    = tok[N];

	for (genvar j = 0; j < N; j++) begin : g_cell
		logic signed [VALUE_W-1:0] nxt;

		// last cell sees its own centre; it never tests a midpoint
		if (j == N - 1) begin : g_last
			assign nxt = ctr[j];
		end else begin : g_mid
			assign nxt = ctr[j+1];
		end

		tdh_cell #(.IDX(j)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ld_en    (ld_en && (ld_idx == IDX_W'(j))),
			.ld_value (ld_value),
			.c_next   (nxt),
			.used     (used),
			.tok_in   (tok[j]),
			.c_own    (ctr[j]),
			.tok_q    (tok[j+1])
		);
	end

endmodule

`default_nettype wire

// ----- rtl/two_dim_histogram_nearest_center.sv -----
// Two-dimensional histogram against per-dimension bin centres.
// Depends on tdh_pkg, tdh_if, tdh_chain.
//
// Channels: 'sample' (valid/ready) takes one word per operation: load a centre
// of dimension one or two, add a vector, or read a count. 'result' (valid/
// ready) returns one word per add or read: the bin pair and its count.
// Configuration: cfg_we/cfg_index/cfg_data write the bins-in-use registers;
// the user must write them only while the block is idle; the block never checks.
// Sequence: a load writes its centre as it is accepted. An add walks a token
// through the sixteen centre cells of each dimension (both rows in parallel,
// one cell per cycle), then reads and writes the count store; the next word
// is taken only once the block is idle again. A read skips the search and
// goes straight to the count store read and update.
// The result sits in an output register; the block takes new words while it
// waits, and only stalls at the count update if the receiver still holds the
// previous result.
// Reset: registers go to 16 bins, all counts read as zero at once (one valid
// bit per store entry); centres are undefined until loaded.
`default_nettype none

module two_dim_histogram_nearest_center (
	input  wire                          clk,
	input  wire                          arst_n,
	tdh_sample_if.sink                   sample,
	tdh_result_if.source                 result,
	input  wire                          cfg_we,
	input  wire [0:0]                    cfg_index,
	input  wire [tdh_pkg::USED_W-1:0]    cfg_data
);
	import tdh_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_UPD} state_t;

	state_t                 state_q;
	logic [USED_W-1:0]      bins_first_q, bins_second_q;
	logic [USED_W-1:0]      used_first, used_second;
	logic                   acc;
	op_t                    op;
	tok_t                   start_first, start_second, res_first, res_second;
	logic                   got_first_q, got_second_q;
	logic [IDX_W-1:0]       bin_first_q, bin_second_q;
	logic                   is_add_q;
	logic [ADDR_W-1:0]      addr;
	logic [STORE_DEPTH-1:0] vld_q;
	logic                   vld_rd_q;
	logic [COUNT_W-1:0]     mem_q [STORE_DEPTH];
	logic [COUNT_W-1:0]     rd_data_q;
	logic [COUNT_W-1:0]     cur_count, new_count;
	logic                   upd_go;
	logic                   res_valid_q;
	logic [IDX_W-1:0]       res_bin_first_q, res_bin_second_q;
	logic [COUNT_W-1:0]     res_count_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_first_q  <= USED_W'(BINS_FIRST);
			bins_second_q <= USED_W'(BINS_SECOND);
		end else if (cfg_we) begin
			if (cfg_index == REG_BINS_FIRST) begin
				bins_first_q <= cfg_data;
			end
			if (cfg_index == REG_BINS_SECOND) begin
				bins_second_q <= cfg_data;
			end
		end
	end

	// bins in use, zero acts as one, above the row length as the row length
	always_comb begin
		if (bins_first_q == '0)
			used_first = USED_W'(1);
		else if (bins_first_q > USED_W'(BINS_FIRST))
			used_first = USED_W'(BINS_FIRST);
		else
			used_first = bins_first_q;
		if (bins_second_q == '0)
			used_second = USED_W'(1);
		else if (bins_second_q > USED_W'(BINS_SECOND))
			used_second = USED_W'(BINS_SECOND);
		else
			used_second = bins_second_q;
	end

	// sample handshake and token launch
	assign sample.ready = (state_q == S_IDLE);
	assign acc          = sample.valid && sample.ready;
	assign op           = op_t'(sample.op);

	always_comb begin
		start_first       = '0;
		start_first.valid = acc && (op == OP_ADD);
		start_first.v2    = {sample.value_first, 1'b0};
		start_second       = '0;
		start_second.valid = acc && (op == OP_ADD);
		start_second.v2    = {sample.value_second, 1'b0};
	end

	tdh_chain #(.N(BINS_FIRST)) u_chain_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_en     (acc && (op == OP_LOAD_FIRST)),
		.ld_idx    (sample.index_first),
		.ld_value  (sample.value_first),
		.used      (used_first),
		.tok_start (start_first),
		.res       (res_first)
	);

	tdh_chain #(.N(BINS_SECOND)) u_chain_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_en     (acc && (op == OP_LOAD_SECOND)),
		.ld_idx    (sample.index_first),
		.ld_value  (sample.value_first),
		.used      (used_second),
		.tok_start (start_second),
		.res       (res_second)
	);

	// count store address: second bin in the upper bits
	assign addr = {bin_second_q, bin_first_q};

	// count update, saturating
	always_comb begin
		cur_count = vld_rd_q ? rd_data_q : '0;
		if (is_add_q && (cur_count != COUNT_MAX))
			new_count = cur_count + COUNT_W'(1);
		else
			new_count = cur_count;
		upd_go = (state_q == S_UPD) && (!res_valid_q || result.ready);
	end

	// count store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (upd_go && is_add_q) begin
			mem_q[addr] <= new_count;
		end
		if (state_q == S_READ) begin
			rd_data_q <= mem_q[addr];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			got_first_q      <= 1'b0;
			got_second_q     <= 1'b0;
			is_add_q         <= 1'b0;
			vld_q            <= '0;
			vld_rd_q         <= 1'b0;
			res_valid_q      <= 1'b0;
			bin_first_q      <= '0;
			bin_second_q     <= '0;
			res_bin_first_q  <= '0;
			res_bin_second_q <= '0;
			res_count_q      <= '0;
		end else begin
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			// catch each row's answer as it leaves the last cell
			if (res_first.valid) begin
				bin_first_q <= res_first.bin;
				got_first_q <= 1'b1;
			end
			if (res_second.valid) begin
				bin_second_q <= res_second.bin;
				got_second_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (op)
							OP_ADD: begin
								is_add_q <= 1'b1;
								state_q  <= S_SCAN;
							end
							OP_READ: begin
								is_add_q     <= 1'b0;
								bin_first_q  <= sample.index_first;
								bin_second_q <= sample.index_second;
								state_q      <= S_READ;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (got_first_q && got_second_q) begin
						got_first_q  <= 1'b0;
						got_second_q <= 1'b0;
						state_q      <= S_READ;
					end
				end
				S_READ: begin
					vld_rd_q <= vld_q[addr];
					state_q  <= S_UPD;
				end
				S_UPD: begin
					if (upd_go) begin
						if (is_add_q) begin
							vld_q[addr] <= 1'b1;
						end
						res_valid_q      <= 1'b1;
						res_bin_first_q  <= bin_first_q;
						res_bin_second_q <= bin_second_q;
						res_count_q      <= new_count;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid      = res_valid_q;
	assign result.bin_first  = res_bin_first_q;
	assign result.bin_second = res_bin_second_q;
	assign result.count      = res_count_q;

	// a row answer only arrives while an add is being searched
	a_row_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(res_first.valid || res_second.valid) |-> (state_q == S_SCAN))
		else $error("search token left a row outside the scan");

	// a new result only follows a count update
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_UPD))
		else $error("result raised without a count update");

	// an added vector never reports a zero count
	a_add_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && is_add_q) |=> (res_count_q != '0))
		else $error("add produced a zero count");

endmodule

`default_nettype wire
